/* rtl/sofp_pkg.sv */
package sofp_pkg;

	// field widths
	localparam int DATA_W   = 24;
	localparam int VEL_W    = 16;
	localparam int COND_W   = 16;
	localparam int DETL_W   = 24;
	localparam int SPD_W    = 15;
	localparam int REASON_W = 2;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_COND  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DET   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED = 2'd2;

	localparam logic [COND_W-1:0] COND_RST = 16'd62259;
	localparam logic [DETL_W-1:0] DET_RST  = 24'd6554;
	localparam logic [SPD_W-1:0]  SPD_RST  = 15'd20480;

	// reject reasons
	localparam logic [REASON_W-1:0] RSN_OK   = 2'd0;
	localparam logic [REASON_W-1:0] RSN_COND = 2'd1;
	localparam logic [REASON_W-1:0] RSN_DET  = 2'd2;
	localparam logic [REASON_W-1:0] RSN_FAST = 2'd3;

	localparam int FRAC_BITS_DEF = 12;

	// datapath widths
	localparam int PROD_W    = 2 * DATA_W;      // one derivative product
	localparam int N1_W      = 2 * DATA_W + 1;  // xy * (xx + yy)
	localparam int SUM_W     = PROD_W + 2;      // signed sum of three products
	localparam int MAG_W     = PROD_W;          // magnitude of any such sum
	localparam int LIM2_W    = 2 * COND_W;
	localparam int BIG_W     = 2 * MAG_W;       // product of two magnitudes
	localparam int LP_W      = LIM2_W + MAG_W;
	localparam int RHS_W     = LP_W + MAG_W;
	localparam int SYS_W     = BIG_W + 2;       // signed determinant / numerator
	localparam int AMAG_W    = SYS_W - 1;
	localparam int MUL_DIG_W = 24;

	typedef struct packed {
		logic rej_cond;
		logic rej_det;
		logic neg_x;
		logic neg_y;
	} side_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic                    flow_valid;
		logic [REASON_W-1:0]     reason;
	} res_t;

endpackage

/* rtl/sofp_if.sv */
interface sofp_in_if;
	logic valid;
	logic ready;
	logic signed [sofp_pkg::DATA_W-1:0] grad_x;
	logic signed [sofp_pkg::DATA_W-1:0] grad_y;
	logic signed [sofp_pkg::DATA_W-1:0] grad_xx;
	logic signed [sofp_pkg::DATA_W-1:0] grad_yy;
	logic signed [sofp_pkg::DATA_W-1:0] grad_xy;
	logic signed [sofp_pkg::DATA_W-1:0] grad_t;
	logic signed [sofp_pkg::DATA_W-1:0] grad_xt;
	logic signed [sofp_pkg::DATA_W-1:0] grad_yt;

	modport source (output valid, grad_x, grad_y, grad_xx, grad_yy, grad_xy,
		grad_t, grad_xt, grad_yt, input ready);
	modport sink (input valid, grad_x, grad_y, grad_xx, grad_yy, grad_xy,
		grad_t, grad_xt, grad_yt, output ready);
endinterface

interface sofp_out_if;
	logic valid;
	logic ready;
	logic signed [sofp_pkg::VEL_W-1:0] vel_x;
	logic signed [sofp_pkg::VEL_W-1:0] vel_y;
	logic flow_valid;
	logic [sofp_pkg::REASON_W-1:0] reject_reason;

	modport source (output valid, vel_x, vel_y, flow_valid, reject_reason, input ready);
	modport sink (input valid, vel_x, vel_y, flow_valid, reject_reason, output ready);
endinterface

interface sofp_cfg_if;
	logic valid;
	logic ready;
	logic [sofp_pkg::CFG_IDX_W-1:0] index;
	logic [sofp_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/sofp_umul.sv */
module sofp_umul #(
	parameter int AW = 48,
	parameter int BW = 48
) (
	input  logic          clk,
	input  logic          en,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	output logic [AW+BW-1:0] p
);
	import sofp_pkg::*;

	// digit products are registered in pp_q, their shifted sum in p_q
	localparam int NA = (AW + MUL_DIG_W - 1) / MUL_DIG_W;
	localparam int NB = (BW + MUL_DIG_W - 1) / MUL_DIG_W;
	localparam int AP = NA * MUL_DIG_W;
	localparam int BP = NB * MUL_DIG_W;
	localparam int PW = 2 * MUL_DIG_W;
	localparam int SW = AP + BP;

	logic [AP-1:0] a_pad;
	logic [BP-1:0] b_pad;
	logic [PW-1:0] pp_q [NA*NB];
	logic [SW-1:0] sum;
	logic [AW+BW-1:0] p_q;

	assign a_pad = AP'(a);
	assign b_pad = BP'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_q[i*NB+j] <= PW'(a_pad[i*MUL_DIG_W +: MUL_DIG_W])
						* PW'(b_pad[j*MUL_DIG_W +: MUL_DIG_W]);
				end
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				sum = sum + (SW'(pp_q[i*NB+j]) << ((i + j) * MUL_DIG_W));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= sum[AW+BW-1:0];
		end
	end

	assign p = p_q;

endmodule

/* rtl/sofp_div.sv */
module sofp_div #(
	parameter int FRAC_BITS = sofp_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_v,
	input  sofp_pkg::side_t in_side,
	input  logic [sofp_pkg::AMAG_W-1:0] in_den,
	input  logic [1:0][sofp_pkg::AMAG_W-1:0] in_num,
	output logic out_v,
	output sofp_pkg::side_t out_side,
	output logic [1:0][sofp_pkg::SPD_W-1:0] out_q,
	output logic [1:0] out_big
);
	import sofp_pkg::*;

	// restoring division, one quotient bit per stage, two lanes share the divisor
	localparam int XW  = (FRAC_BITS > SPD_W) ? FRAC_BITS : SPD_W;
	localparam int RW  = AMAG_W + XW;
	localparam int NST = SPD_W + 1;

	logic [NST-1:0]    v_q;
	side_t             side_q [NST];
	logic [AMAG_W-1:0] den_q  [NST];
	logic [RW-1:0]     rem_q  [NST][2];
	logic [SPD_W-1:0]  quo_q  [NST][2];
	logic              big_q  [NST][2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NST-2:0], in_v};
		end
	end

	always_ff @(posedge clk) begin
		logic [RW-1:0] num;
		logic [RW-1:0] dsh;
		logic          take;
		if (en) begin
			// entry: quotient of 2^SPD_W or more is out of range anyway
			side_q[0] <= in_side;
			den_q[0]  <= in_den;
			for (int l = 0; l < 2; l++) begin
				num = RW'(in_num[l]) << FRAC_BITS;
				dsh = RW'(in_den) << SPD_W;
				rem_q[0][l] <= num;
				quo_q[0][l] <= '0;
				big_q[0][l] <= (num >= dsh);
			end
			for (int k = 1; k < NST; k++) begin
				side_q[k] <= side_q[k-1];
				den_q[k]  <= den_q[k-1];
				for (int l = 0; l < 2; l++) begin
					dsh  = RW'(den_q[k-1]) << (SPD_W - k);
					take = (rem_q[k-1][l] >= dsh);
					rem_q[k][l] <= take ? rem_q[k-1][l] - dsh : rem_q[k-1][l];
					quo_q[k][l] <= quo_q[k-1][l] | (SPD_W'(take) << (SPD_W - k));
					big_q[k][l] <= big_q[k-1][l];
				end
			end
		end
	end

	assign out_v    = v_q[NST-1];
	assign out_side = side_q[NST-1];
	assign out_q[0] = quo_q[NST-1][0];
	assign out_q[1] = quo_q[NST-1][1];
	assign out_big  = {big_q[NST-1][1], big_q[NST-1][0]};

endmodule

/* rtl/second_order_flow_pixel_solver_core.sv */
// Channel  Dir  Kind       Payload
// cfg      in   write      index (0 cond_limit, 1 det_limit, 2 speed_limit), data
// pix      in   request    grad_x grad_y grad_xx grad_yy grad_xy grad_t grad_xt grad_yt
// flow     out  request    vel_x vel_y flow_valid reject_reason
//
// One pixel per clock while the output queue is not full; an accepted pixel passes
// through 6 arithmetic stages, the 16-rank restoring divider and the queue to flow.valid.
// arst_n clears valid bits, the output queue and the limits to their defaults.
// A two-entry output queue takes the pipeline's result; the whole pipeline
// freezes only while that queue is full, so nothing is dropped or repeated.
// cfg is always ready; writes are only expected while the block is idle.
module second_order_flow_pixel_solver_core #(
	parameter int FRAC_BITS = sofp_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	sofp_cfg_if.sink   cfg,
	sofp_in_if.sink    pix,
	sofp_out_if.source flow
);
	import sofp_pkg::*;

	localparam int FIFO_DEPTH = 2;
	localparam int DET_SH     = 4 * FRAC_BITS - 16;

	function automatic logic signed [SYS_W-1:0] sgnv(input logic [BIG_W-1:0] m,
		input logic neg);
		logic signed [SYS_W-1:0] e;
		e = $signed(SYS_W'(m));
		return neg ? -e : e;
	endfunction

	// ---------------------------------------------------------------- config
	logic [COND_W-1:0] cond_q;
	logic [DETL_W-1:0] det_q;
	logic [SPD_W-1:0]  spd_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cond_q <= COND_RST;
			det_q  <= DET_RST;
			spd_q  <= SPD_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_COND:  cond_q <= cfg.data[COND_W-1:0];
				REG_DET:   det_q  <= cfg.data[DETL_W-1:0];
				REG_SPEED: spd_q  <= cfg.data[SPD_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- flow control
	logic adv;
	logic [1:0] cnt_q;
	logic wr_q, rd_q;
	res_t fifo_q [FIFO_DEPTH];

	// all stages move together; they hold only while the output queue is full
	assign adv       = (cnt_q != 2'(FIFO_DEPTH));
	assign pix.ready = adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
		end else if (adv) begin
			v_s1 <= pix.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// ---------------------------------------------------------------- stage 1
	// all 24x24 derivative products, plus the 24x25 product n1 = xy * (xx + yy)
	logic signed [PROD_W-1:0] x_x_s1, y_y_s1, xx_xx_s1, yy_yy_s1, xy_xy_s1;
	logic signed [PROD_W-1:0] x_y_s1, xx_xy_s1, yy_xy_s1;
	logic signed [PROD_W-1:0] x_t_s1, xx_xt_s1, xy_yt_s1, y_t_s1, xy_xt_s1, yy_yt_s1;
	logic signed [N1_W-1:0]   n1_s1;
	logic signed [DATA_W:0]   hsum;

	assign hsum = (DATA_W+1)'(pix.grad_xx) + (DATA_W+1)'(pix.grad_yy);

	always_ff @(posedge clk) begin
		if (adv) begin
			x_x_s1   <= PROD_W'(pix.grad_x)  * PROD_W'(pix.grad_x);
			y_y_s1   <= PROD_W'(pix.grad_y)  * PROD_W'(pix.grad_y);
			xx_xx_s1 <= PROD_W'(pix.grad_xx) * PROD_W'(pix.grad_xx);
			yy_yy_s1 <= PROD_W'(pix.grad_yy) * PROD_W'(pix.grad_yy);
			xy_xy_s1 <= PROD_W'(pix.grad_xy) * PROD_W'(pix.grad_xy);
			x_y_s1   <= PROD_W'(pix.grad_x)  * PROD_W'(pix.grad_y);
			xx_xy_s1 <= PROD_W'(pix.grad_xx) * PROD_W'(pix.grad_xy);
			yy_xy_s1 <= PROD_W'(pix.grad_yy) * PROD_W'(pix.grad_xy);
			x_t_s1   <= PROD_W'(pix.grad_x)  * PROD_W'(pix.grad_t);
			xx_xt_s1 <= PROD_W'(pix.grad_xx) * PROD_W'(pix.grad_xt);
			xy_yt_s1 <= PROD_W'(pix.grad_xy) * PROD_W'(pix.grad_yt);
			y_t_s1   <= PROD_W'(pix.grad_y)  * PROD_W'(pix.grad_t);
			xy_xt_s1 <= PROD_W'(pix.grad_xy) * PROD_W'(pix.grad_xt);
			yy_yt_s1 <= PROD_W'(pix.grad_yy) * PROD_W'(pix.grad_yt);
			n1_s1    <= N1_W'(pix.grad_xy) * N1_W'(hsum);
		end
	end

	// ---------------------------------------------------------------- stage 2
	// normal-equation terms, split into magnitude and sign; squared cond_limit
	logic signed [SUM_W-1:0] d2, tn1, tn2;
	logic [MAG_W-1:0] p1, p2;
	logic [MAG_W-1:0] d1_s2, d3_s2, d2m_s2, tn1m_s2, tn2m_s2, n1m_s2, p1_s2, p2_s2;
	logic d2n_s2, tn1n_s2, tn2n_s2, pzero_s2;
	logic [LIM2_W-1:0] lim2_s2;

	assign d2  = SUM_W'(x_y_s1) + SUM_W'(xx_xy_s1) + SUM_W'(yy_xy_s1);
	assign tn1 = SUM_W'(x_t_s1) + SUM_W'(xx_xt_s1) + SUM_W'(xy_yt_s1);
	assign tn2 = SUM_W'(y_t_s1) + SUM_W'(xy_xt_s1) + SUM_W'(yy_yt_s1);
	assign p1  = MAG_W'(xx_xx_s1) + MAG_W'(xy_xy_s1);
	assign p2  = MAG_W'(yy_yy_s1) + MAG_W'(xy_xy_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s2    <= p1;
			p2_s2    <= p2;
			pzero_s2 <= (p1 == '0) || (p2 == '0);
			d1_s2    <= MAG_W'(x_x_s1) + p1;
			d3_s2    <= MAG_W'(y_y_s1) + p2;
			d2m_s2   <= d2[SUM_W-1]  ? MAG_W'(-d2)  : MAG_W'(d2);
			tn1m_s2  <= tn1[SUM_W-1] ? MAG_W'(-tn1) : MAG_W'(tn1);
			tn2m_s2  <= tn2[SUM_W-1] ? MAG_W'(-tn2) : MAG_W'(tn2);
			n1m_s2   <= n1_s1[N1_W-1] ? MAG_W'(-n1_s1) : MAG_W'(n1_s1);
			d2n_s2   <= d2[SUM_W-1];
			tn1n_s2  <= tn1[SUM_W-1];
			tn2n_s2  <= tn2[SUM_W-1];
			lim2_s2  <= LIM2_W'(cond_q) * LIM2_W'(cond_q);
		end
	end

	// ---------------------------------------------------------------- stages 3-4
	// wide products through the digit multipliers
	logic [BIG_W-1:0] d1d3_s4, d2d2_s4, pa_s4, pb_s4, pc_s4, pd_s4, n1sq_s4;
	logic [LP_W-1:0]  lp_s4;
	logic [3:0] sgn_s3, sgn_s4;   // signs of pa, pb, pc, pd
	logic pzero_s3, pzero_s4;
	logic [MAG_W-1:0] p2_s3, p2_s4;

	sofp_umul #(.AW(MAG_W), .BW(MAG_W)) u_d1d3 (.clk, .en(adv), .a(d1_s2),  .b(d3_s2),
		.p(d1d3_s4));
	sofp_umul #(.AW(MAG_W), .BW(MAG_W)) u_d2d2 (.clk, .en(adv), .a(d2m_s2), .b(d2m_s2),
		.p(d2d2_s4));
	sofp_umul #(.AW(MAG_W), .BW(MAG_W)) u_pa (.clk, .en(adv), .a(d2m_s2), .b(tn2m_s2),
		.p(pa_s4));
	sofp_umul #(.AW(MAG_W), .BW(MAG_W)) u_pb (.clk, .en(adv), .a(d3_s2), .b(tn1m_s2),
		.p(pb_s4));
	sofp_umul #(.AW(MAG_W), .BW(MAG_W)) u_pc (.clk, .en(adv), .a(d2m_s2), .b(tn1m_s2),
		.p(pc_s4));
	sofp_umul #(.AW(MAG_W), .BW(MAG_W)) u_pd (.clk, .en(adv), .a(d1_s2), .b(tn2m_s2),
		.p(pd_s4));
	sofp_umul #(.AW(MAG_W), .BW(MAG_W)) u_n1 (.clk, .en(adv), .a(n1m_s2), .b(n1m_s2),
		.p(n1sq_s4));
	sofp_umul #(.AW(LIM2_W), .BW(MAG_W)) u_lp (.clk, .en(adv), .a(lim2_s2), .b(p1_s2),
		.p(lp_s4));

	always_ff @(posedge clk) begin
		if (adv) begin
			sgn_s3   <= {d2n_s2 ^ tn2n_s2, tn1n_s2, d2n_s2 ^ tn1n_s2, tn2n_s2};
			sgn_s4   <= sgn_s3;
			pzero_s3 <= pzero_s2;
			pzero_s4 <= pzero_s3;
			p2_s3    <= p2_s2;
			p2_s4    <= p2_s3;
		end
	end

	// ---------------------------------------------------------------- stage 5
	// determinant and Cramer numerators; conditioning product goes on
	logic signed [SYS_W-1:0] den_s5, numx_s5, numy_s5;
	logic [BIG_W-1:0] n1sq_s5;
	logic pzero_s5;
	logic [RHS_W-1:0] rhs_s6;

	sofp_umul #(.AW(LP_W), .BW(MAG_W)) u_rhs (.clk, .en(adv), .a(lp_s4), .b(p2_s4),
		.p(rhs_s6));

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s5   <= sgnv(d1d3_s4, 1'b0) - sgnv(d2d2_s4, 1'b0);
			numx_s5  <= sgnv(pa_s4, sgn_s4[3]) - sgnv(pb_s4, sgn_s4[2]);
			numy_s5  <= sgnv(pc_s4, sgn_s4[1]) - sgnv(pd_s4, sgn_s4[0]);
			n1sq_s5  <= n1sq_s4;
			pzero_s5 <= pzero_s4;
		end
	end

	// ---------------------------------------------------------------- stage 6
	// magnitudes, quotient signs, determinant threshold
	logic [AMAG_W-1:0] aden, det_thr;
	logic [AMAG_W-1:0] aden_s6;
	logic [1:0][AMAG_W-1:0] mag_s6;
	logic negx_s6, negy_s6, rejdet_s6, pzero_s6;
	logic [BIG_W-1:0] n1sq_s6;

	assign aden    = den_s5[SYS_W-1] ? AMAG_W'(-den_s5) : AMAG_W'(den_s5);
	// |den| * 2^16 <= det_limit * 2^(4F)  <=>  |den| <= det_limit << (4F - 16)
	assign det_thr = AMAG_W'(det_q) << DET_SH;

	always_ff @(posedge clk) begin
		if (adv) begin
			aden_s6   <= aden;
			mag_s6[0] <= numx_s5[SYS_W-1] ? AMAG_W'(-numx_s5) : AMAG_W'(numx_s5);
			mag_s6[1] <= numy_s5[SYS_W-1] ? AMAG_W'(-numy_s5) : AMAG_W'(numy_s5);
			negx_s6   <= numx_s5[SYS_W-1] ^ den_s5[SYS_W-1];
			negy_s6   <= numy_s5[SYS_W-1] ^ den_s5[SYS_W-1];
			rejdet_s6 <= (aden <= det_thr);
			n1sq_s6   <= n1sq_s5;
			pzero_s6  <= pzero_s5;
		end
	end

	// ---------------------------------------------------------------- divider
	// conditioning: n1^2 * 2^32 <= cond_limit^2 * P1 * P2, compared on entry
	side_t div_side_in, div_side;
	logic div_v;
	logic [1:0][SPD_W-1:0] div_q;
	logic [1:0] div_big;

	assign div_side_in.rej_cond = pzero_s6 || ({n1sq_s6, LIM2_W'(0)} > rhs_s6);
	assign div_side_in.rej_det  = rejdet_s6;
	assign div_side_in.neg_x    = negx_s6;
	assign div_side_in.neg_y    = negy_s6;

	sofp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk,
		.arst_n,
		.en       (adv),
		.in_v     (v_s6),
		.in_side  (div_side_in),
		.in_den   (aden_s6),
		.in_num   (mag_s6),
		.out_v    (div_v),
		.out_side (div_side),
		.out_q    (div_q),
		.out_big  (div_big)
	);

	// ---------------------------------------------------------------- result
	// reasons in priority order: conditioning, determinant, speed
	res_t res;
	logic fast;
	logic [VEL_W-1:0] qx, qy;

	assign fast = div_big[0] || div_big[1] || (div_q[0] > spd_q) || (div_q[1] > spd_q);
	assign qx   = VEL_W'(div_q[0]);
	assign qy   = VEL_W'(div_q[1]);

	always_comb begin
		if (div_side.rej_cond) begin
			res.reason = RSN_COND;
		end else if (div_side.rej_det) begin
			res.reason = RSN_DET;
		end else if (fast) begin
			res.reason = RSN_FAST;
		end else begin
			res.reason = RSN_OK;
		end
		res.flow_valid = (res.reason == RSN_OK);
		if (res.flow_valid) begin
			res.vel_x = $signed(div_side.neg_x ? -qx : qx);
			res.vel_y = $signed(div_side.neg_y ? -qy : qy);
		end else begin
			res.vel_x = '0;
			res.vel_y = '0;
		end
	end

	// ---------------------------------------------------------------- output queue
	logic push, pop;

	assign push = adv && div_v;
	assign pop  = flow.valid && flow.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= res;
		end
	end

	assign flow.valid         = (cnt_q != '0);
	assign flow.vel_x         = fifo_q[rd_q].vel_x;
	assign flow.vel_y         = fifo_q[rd_q].vel_y;
	assign flow.flow_valid    = fifo_q[rd_q].flow_valid;
	assign flow.reject_reason = fifo_q[rd_q].reason;

	// ---------------------------------------------------------------- checks
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(FIFO_DEPTH))
		else $error("output queue overflow");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		flow.valid && !flow.flow_valid |-> flow.vel_x == '0 && flow.vel_y == '0)
		else $error("rejected pixel with nonzero velocity");

	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		flow.valid |-> flow.flow_valid == (flow.reject_reason == RSN_OK))
		else $error("flow_valid disagrees with reject_reason");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'(FIFO_DEPTH) && !pop |=> cnt_q == 2'(FIFO_DEPTH))
		else $error("full queue took a result");

endmodule

/* sim/tb_second_order_flow_pixel_solver_core.sv */
module tb_second_order_flow_pixel_solver_core;
	import sofp_pkg::*;

	// One pixel's derivative set, in port order.
	typedef struct {
		logic signed [DATA_W-1:0] gx, gy, gxx, gyy, gxy, gt, gxt, gyt;
	} pixel_t;

	// Scoreboard: owns its own copy of the three limits and a queue of expected
	// flow results. Predictions are made with wide signed vectors.
	class flow_scoreboard;
		logic [COND_W-1:0] cond_lim;
		logic [DETL_W-1:0] det_lim;
		logic [SPD_W-1:0]  spd_lim;
		res_t              pending[$];
		int                mismatches;

		function void reset_limits();
			cond_lim = COND_RST;
			det_lim  = DET_RST;
			spd_lim  = SPD_RST;
		endfunction

		function void write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_COND:  cond_lim = val[COND_W-1:0];
				REG_DET:   det_lim  = val[DETL_W-1:0];
				REG_SPEED: spd_lim  = val[SPD_W-1:0];
				default: ;
			endcase
		endfunction

		// Solve one pixel the way the block must.
		function res_t solve_pixel(pixel_t p);
			logic signed [255:0] x, y, xx, yy, xy, t, xt, yt;
			logic signed [255:0] n1, p1, p2, lhs, rhs, d1, d2, d3, den, aden;
			logic signed [255:0] tn1, tn2, numx, numy, qx, qy;
			res_t r;
			x = p.gx; y = p.gy; xx = p.gxx; yy = p.gyy; xy = p.gxy;
			t = p.gt; xt = p.gxt; yt = p.gyt;
			r = '{vel_x: '0, vel_y: '0, flow_valid: 1'b0, reason: RSN_OK};
			// Hessian conditioning; a zero denominator rejects outright
			n1 = xy * (xx + yy);
			p1 = xx * xx + xy * xy;
			p2 = yy * yy + xy * xy;
			lhs = (n1 * n1) <<< 32;
			rhs = $signed({240'd0, cond_lim}) * $signed({240'd0, cond_lim}) * p1 * p2;
			if (p1 == 0 || p2 == 0 || lhs > rhs) begin
				r.reason = RSN_COND;
				return r;
			end
			d1 = x * x + xx * xx + xy * xy;
			d2 = x * y + xx * xy + yy * xy;
			d3 = y * y + yy * yy + xy * xy;
			den = d1 * d3 - d2 * d2;
			aden = den < 0 ? -den : den;
			// det limit is Q8.16, den carries 4*FRAC_BITS fractional bits
			if ((aden <<< 16) <= ($signed({232'd0, det_lim}) <<< (4 * FRAC_BITS_DEF))) begin
				r.reason = RSN_DET;
				return r;
			end
			tn1 = x * t + xx * xt + xy * yt;
			tn2 = y * t + xy * xt + yy * yt;
			numx = d2 * tn2 - d3 * tn1;
			numy = d2 * tn1 - d1 * tn2;
			// truncating division toward zero on magnitudes
			qx = ((numx < 0 ? -numx : numx) <<< FRAC_BITS_DEF) / aden;
			qy = ((numy < 0 ? -numy : numy) <<< FRAC_BITS_DEF) / aden;
			if (qx > spd_lim || qy > spd_lim) begin
				r.reason = RSN_FAST;
				return r;
			end
			r.vel_x = ((numx < 0) != (den < 0)) ? -qx[VEL_W-1:0] : qx[VEL_W-1:0];
			r.vel_y = ((numy < 0) != (den < 0)) ? -qy[VEL_W-1:0] : qy[VEL_W-1:0];
			r.flow_valid = 1'b1;
			return r;
		endfunction

		function void note_pixel(pixel_t p);
			pending.push_back(solve_pixel(p));
		endfunction

		function void check_flow(res_t got);
			res_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected flow result %p", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got.vel_x !== exp_r.vel_x || got.vel_y !== exp_r.vel_y ||
					got.flow_valid !== exp_r.flow_valid || got.reason !== exp_r.reason) begin
				mismatches++;
				if (mismatches <= 10)
					$display("flow mismatch: expected %p, got %p", exp_r, got);
			end
		endfunction
	endclass

	localparam int LATENCY    = 23;
	localparam int STALL_LIMIT = 5000;

	logic clk;
	logic arst_n;

	sofp_cfg_if cfg_bus();
	sofp_in_if  pix_bus();
	sofp_out_if flow_bus();

	second_order_flow_pixel_solver_core DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_bus.sink),
		.pix   (pix_bus.sink),
		.flow  (flow_bus.source)
	);

	flow_scoreboard sb;

	// idle rates in percent for the sender and the receiver
	int src_idle_pct;
	int snk_stall_pct;
	int idle_cycles;
	int n_pix;
	int n_flow;
	int n_cond, n_det, n_fast, n_ok;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: ready changes on the falling edge, results sampled on rising.
	initial begin
		flow_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			flow_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && flow_bus.valid && flow_bus.ready) begin
			res_t got;
			got = '{vel_x: flow_bus.vel_x, vel_y: flow_bus.vel_y,
				flow_valid: flow_bus.flow_valid, reason: flow_bus.reject_reason};
			sb.check_flow(got);
			n_flow++;
			case (got.reason)
				RSN_OK:   n_ok++;
				RSN_COND: n_cond++;
				RSN_DET:  n_det++;
				default:  n_fast++;
			endcase
		end
	end

	// Watchdog: cycles without any accepted request or result.
	always @(posedge clk) begin
		if ((pix_bus.valid && pix_bus.ready) || (flow_bus.valid && flow_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress, %0d results outstanding", sb.pending.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		cfg_bus.valid <= 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		sb.write_limit(idx, val);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
		@(negedge clk);
	endtask

	// valid stays high after an accept so requests can follow back to back
	task automatic send_pixel(pixel_t p);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_bus.valid <= 1'b0;
			@(negedge clk);
		end
		pix_bus.grad_x  <= p.gx;  pix_bus.grad_y  <= p.gy;
		pix_bus.grad_xx <= p.gxx; pix_bus.grad_yy <= p.gyy;
		pix_bus.grad_xy <= p.gxy; pix_bus.grad_t  <= p.gt;
		pix_bus.grad_xt <= p.gxt; pix_bus.grad_yt <= p.gyt;
		pix_bus.valid   <= 1'b1;
		do @(posedge clk); while (!pix_bus.ready);
		sb.note_pixel(p);
		n_pix++;
		@(negedge clk);
	endtask

	// Wait for every outstanding result, then let the pipeline drain.
	task automatic drain();
		pix_bus.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// Random 24-bit value: mostly small magnitudes so the solver accepts often,
	// sometimes the full range to reach every bit.
	function automatic logic signed [DATA_W-1:0] rand_grad();
		int sel;
		sel = $urandom_range(9);
		if (sel < 6) return $signed(DATA_W'($urandom_range(16384))) - 24'sd8192;
		if (sel < 8) return $signed(DATA_W'($urandom_range(1048576))) - 24'sd524288;
		return DATA_W'($urandom);
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p.gx = rand_grad(); p.gy = rand_grad();
		p.gxx = rand_grad(); p.gyy = rand_grad(); p.gxy = rand_grad();
		p.gt = rand_grad(); p.gxt = rand_grad(); p.gyt = rand_grad();
		// well-conditioned Hessian: shrink the mixed term
		if ($urandom_range(3) != 0) p.gxy = p.gxy >>> $urandom_range(12, 4);
		// small temporal terms keep the velocity under the limit
		if ($urandom_range(2) == 0) begin
			p.gt = p.gt >>> 6; p.gxt = p.gxt >>> 6; p.gyt = p.gyt >>> 6;
		end
		return p;
	endfunction

	function automatic pixel_t mk(int a, int b, int c, int d, int e, int f, int g, int h);
		pixel_t p;
		p.gx  = DATA_W'(a); p.gy  = DATA_W'(b); p.gxx = DATA_W'(c); p.gyy = DATA_W'(d);
		p.gxy = DATA_W'(e); p.gt  = DATA_W'(f); p.gxt = DATA_W'(g); p.gyt = DATA_W'(h);
		return p;
	endfunction

	localparam int MAXP = 8388607;
	localparam int MINN = -8388608;

	initial begin
		pixel_t p;
		sb = new();
		sb.reset_limits();
		src_idle_pct = 0; snk_stall_pct = 0;
		idle_cycles = 0; n_pix = 0; n_flow = 0;
		n_cond = 0; n_det = 0; n_fast = 0; n_ok = 0;
		cfg_bus.valid = 1'b0; cfg_bus.index = REG_COND; cfg_bus.data = '0;
		pix_bus.valid = 1'b0;
		pix_bus.grad_x = '0; pix_bus.grad_y = '0; pix_bus.grad_xx = '0;
		pix_bus.grad_yy = '0; pix_bus.grad_xy = '0; pix_bus.grad_t = '0;
		pix_bus.grad_xt = '0; pix_bus.grad_yt = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at reset defaults.
		send_pixel(mk(0, 0, 0, 0, 0, 0, 0, 0));              // zero Hessian: both P zero
		send_pixel(mk(4096, 0, 0, 4096, 0, 100, 0, 0));       // xx zero, xy zero: P1 zero
		send_pixel(mk(0, 0, 4096, 4096, 4096, 0, 0, 0));      // ill conditioned
		send_pixel(mk(0, 0, 4096, 4096, 0, 4096, 4096, 4096)); // identity, accepted
		send_pixel(mk(0, 0, 4096, -4096, 0, -4096, -4096, 4096));
		send_pixel(mk(0, 0, 8, 8, 0, 0, 0, 0));               // tiny determinant
		send_pixel(mk(0, 0, 4096, 4096, 0, 0, 40000, 0));     // too fast in x
		send_pixel(mk(0, 0, 4096, 4096, 0, 0, 0, -40000));    // too fast in y
		send_pixel(mk(0, 0, 4096, 4096, 0, 0, -20480, 20480)); // exactly at the limit
		send_pixel(mk(MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP));
		send_pixel(mk(MINN, MINN, MINN, MINN, MINN, MINN, MINN, MINN));
		send_pixel(mk(MAXP, MINN, MAXP, MINN, 0, MAXP, MINN, MAXP));
		send_pixel(mk(MINN, MAXP, MINN, MAXP, -1, MINN, MAXP, MINN));
		send_pixel(mk(-1, -1, -1, -1, -1, -1, -1, -1));
		// Drain: hold off until everything already sent has come back.
		drain();

		// Register extremes, then random phases each under a new setting.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_COND, 24'h00ffff); write_reg(REG_DET, 24'h000000);
					write_reg(REG_SPEED, 24'h007fff);
				end
				1: begin
					write_reg(REG_COND, 24'h000000); write_reg(REG_DET, 24'hffffff);
					write_reg(REG_SPEED, 24'h000000);
				end
				2: begin
					write_reg(REG_COND, COND_RST); write_reg(REG_DET, DET_RST);
					write_reg(REG_SPEED, SPD_RST);
				end
				default: begin
					write_reg(REG_COND, CFG_DATA_W'($urandom));
					write_reg(REG_DET, CFG_DATA_W'($urandom_range(65536)));
					write_reg(REG_SPEED, CFG_DATA_W'($urandom));
				end
			endcase
			case (ph % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 81; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 81; end
				default: begin src_idle_pct = 17; snk_stall_pct = 17; end
			endcase
			for (int i = 0; i < 155; i++) begin
				p = rand_pixel();
				send_pixel(p);
			end
			src_idle_pct = 0;
			drain();
		end

		$display("covered %0d pixels over 8 limit settings and four idle mixes", n_pix);
		$display("results: %0d accepted, %0d ill conditioned, %0d small det, %0d too fast",
			n_ok, n_cond, n_det, n_fast);
		if (sb.mismatches == 0 && sb.pending.size() == 0 && n_flow == n_pix)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

/* second_order_flow_pixel_solver_core.f */
rtl/sofp_pkg.sv
rtl/sofp_if.sv
rtl/sofp_umul.sv
rtl/sofp_div.sv
rtl/second_order_flow_pixel_solver_core.sv
sim/tb_second_order_flow_pixel_solver_core.sv
